// File: rtl/glmf_pkg.sv
// ----------------------------------------------------------------------------
// glmf_pkg
// Shared types and constants of the grid local maximum finder: frame limits,
// field widths, register and item codes, and the request passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package glmf_pkg;

  // frame limits and sample format
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;

  // counter and dimension widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

  // port widths fixed by the interface
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 10;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register reset value
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(1024);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // input item kinds
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_DRAIN  = 1'b1
  } kind_e;

  // one classified request for the back end
  typedef struct packed {
    logic             wr_en;    // store the sample into the current row
    logic             decide;   // a pixel is decided by this request
    logic             up_ok;    // upper neighbor exists
    logic             down_ok;  // lower neighbor exists (the new sample)
    logic             mid_sel;  // parity of the row being decided
    logic             last_col; // right neighbor missing
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row_out;
    sample_t          sample;
  } op_t;

endpackage

// File: rtl/glmf_ram.sv
// ----------------------------------------------------------------------------
// glmf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (read-first on a same-address write).
// ----------------------------------------------------------------------------
module glmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/glmf_front.sv
// ----------------------------------------------------------------------------
// glmf_front
// Front end: holds the frame size registers and the raster position,
// accepts every input item while the request queue has room, drops the ones
// that do nothing and turns the rest into requests for the back end.
// ----------------------------------------------------------------------------
module glmf_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [glmf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [glmf_pkg::CFG_W-1:0]         cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic signed [glmf_pkg::SAMPLE_BITS-1:0] sample_value_i,
  // request queue
  input  logic                               full_i,
  output logic                               push_o,
  output glmf_pkg::op_t                      op_o
);

  localparam int COL_W  = glmf_pkg::COL_W;
  localparam int ROW_W  = glmf_pkg::ROW_W;
  localparam int WDIM_W = glmf_pkg::WDIM_W;
  localparam int HDIM_W = glmf_pkg::HDIM_W;

  logic [glmf_pkg::CFG_W-1:0] width_q, height_q;
  logic [WDIM_W-1:0]          eff_w;
  logic [HDIM_W-1:0]          eff_h;
  logic [COL_W-1:0]           col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic [COL_W-1:0]           drain_col_q, drain_col_d;
  logic                       draining_q, draining_d;
  logic                       accept, is_drain;
  logic                       row_last_col, drain_last_col, last_row;

  // frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= glmf_pkg::CFG_DIM_RESET;
      height_q <= glmf_pkg::CFG_DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        glmf_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
        glmf_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp the frame size to the supported range
  always_comb begin
    if (width_q < glmf_pkg::CFG_W'(2)) begin
      eff_w = WDIM_W'(2);
    end else if (width_q > glmf_pkg::MAX_WIDTH) begin
      eff_w = WDIM_W'(glmf_pkg::MAX_WIDTH);
    end else begin
      eff_w = WDIM_W'(width_q);
    end
    if (height_q < glmf_pkg::CFG_W'(2)) begin
      eff_h = HDIM_W'(2);
    end else if (height_q > glmf_pkg::MAX_HEIGHT) begin
      eff_h = HDIM_W'(glmf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = HDIM_W'(height_q);
    end
  end

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_drain   = (kind_i == glmf_pkg::KIND_DRAIN);

  // end of row and end of frame
  assign row_last_col   = (WDIM_W'(col_q) + WDIM_W'(1)) >= eff_w;
  assign drain_last_col = (WDIM_W'(drain_col_q) + WDIM_W'(1)) >= eff_w;
  assign last_row       = (HDIM_W'(row_q) + HDIM_W'(1)) >= eff_h;

  // classify the item, build the request and step the position
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    drain_col_d = drain_col_q;
    draining_d  = draining_q;
    push_o      = 1'b0;
    op_o        = '0;
    op_o.sample = sample_value_i;
    if (is_drain) begin
      op_o.decide   = 1'b1;
      op_o.up_ok    = 1'b1;
      op_o.mid_sel  = ~eff_h[0];
      op_o.last_col = drain_last_col;
      op_o.col      = drain_col_q;
      op_o.row_out  = ROW_W'(eff_h - HDIM_W'(1));
      if (accept && draining_q) begin
        push_o = 1'b1;
        if (drain_last_col) begin
          draining_d  = 1'b0;
          drain_col_d = '0;
        end else begin
          drain_col_d = drain_col_q + COL_W'(1);
        end
      end
    end else begin
      op_o.wr_en    = 1'b1;
      op_o.decide   = (row_q != '0);
      op_o.up_ok    = (row_q > ROW_W'(1));
      op_o.down_ok  = 1'b1;
      op_o.mid_sel  = ~row_q[0];
      op_o.last_col = row_last_col;
      op_o.col      = col_q;
      op_o.row_out  = row_q - ROW_W'(1);
      if (accept && !draining_q) begin
        push_o = 1'b1;
        if (row_last_col) begin
          col_d = '0;
          if (last_row) begin
            row_d       = '0;
            draining_d  = 1'b1;
            drain_col_d = '0;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  // raster position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      drain_col_q <= '0;
      draining_q  <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      drain_col_q <= drain_col_d;
      draining_q  <= draining_d;
    end
  end

endmodule

// File: rtl/glmf_queue.sv
// ----------------------------------------------------------------------------
// glmf_queue
// Short request queue between the front end and the back end, so that
// either side can stall on its own.
// ----------------------------------------------------------------------------
module glmf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  glmf_pkg::op_t push_op_i,
  output logic          full_o,
  output logic          valid_o,
  output glmf_pkg::op_t op_o,
  input  logic          pop_i
);

  localparam int QPTR_W = glmf_pkg::QPTR_W;

  glmf_pkg::op_t       mem_q [glmf_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W + 1)'(glmf_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/glmf_back.sv
// ----------------------------------------------------------------------------
// glmf_back
// Back end: two line stores used by row parity, a three-sample window over
// the row being decided, the peak compare and the output register.
// ----------------------------------------------------------------------------
module glmf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request queue
  input  logic                        q_valid_i,
  input  glmf_pkg::op_t               q_op_i,
  output logic                        q_pop_o,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [glmf_pkg::COORD_W-1:0] peak_row_o,
  output logic [glmf_pkg::COORD_W-1:0] peak_col_o
);

  localparam int COL_W = glmf_pkg::COL_W;
  localparam int SB    = glmf_pkg::SAMPLE_BITS;

  glmf_pkg::op_t         s1_op_q;
  logic                  s1_valid_q;
  logic                  s1_adv, issue;
  logic [COL_W-1:0]      mid_addr, up_addr;
  logic [COL_W-1:0]      raddr_a, raddr_b;
  logic                  we_a, we_b;
  logic [SB-1:0]         rdata_a, rdata_b;
  glmf_pkg::sample_t     right, up, left_q, center_q, col0_q;
  logic                  peak;
  logic                  out_valid_q;
  logic [glmf_pkg::COORD_W-1:0] row_q, col_q;

  // pipeline flow
  assign s1_adv  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign issue   = q_valid_i && (!s1_valid_q || s1_adv);
  assign q_pop_o = issue;

  // line store addressing: decided row at col+1, other row at col
  assign mid_addr = q_op_i.col + COL_W'(1);
  assign up_addr  = q_op_i.col;
  assign raddr_a  = q_op_i.mid_sel ? up_addr : mid_addr;
  assign raddr_b  = q_op_i.mid_sel ? mid_addr : up_addr;
  assign we_a     = issue && q_op_i.wr_en && q_op_i.mid_sel;
  assign we_b     = issue && q_op_i.wr_en && !q_op_i.mid_sel;

  // even rows
  glmf_ram #(
    .WIDTH (SB),
    .DEPTH (glmf_pkg::MAX_WIDTH)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (up_addr),
    .wdata_i (q_op_i.sample),
    .re_i    (issue),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  // odd rows
  glmf_ram #(
    .WIDTH (SB),
    .DEPTH (glmf_pkg::MAX_WIDTH)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (up_addr),
    .wdata_i (q_op_i.sample),
    .re_i    (issue),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // request in the compare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (issue) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_op_q <= q_op_i;
    end
  end

  assign right = s1_op_q.mid_sel ? $signed(rdata_b) : $signed(rdata_a);
  assign up    = s1_op_q.mid_sel ? $signed(rdata_a) : $signed(rdata_b);

  // sliding window; a new row starts from the last column-zero sample
  always_ff @(posedge clk_i) begin
    if (issue && q_op_i.wr_en && (q_op_i.col == '0)) begin
      col0_q <= q_op_i.sample;
    end
    if (s1_adv) begin
      left_q <= center_q;
    end
    if (issue && (q_op_i.col == '0)) begin
      center_q <= col0_q;
    end else if (s1_adv) begin
      center_q <= right;
    end
  end

  // four-neighbor compare, ties count as peaks
  always_comb begin
    peak = s1_op_q.decide;
    if (s1_op_q.up_ok && (center_q < up)) begin
      peak = 1'b0;
    end
    if (s1_op_q.down_ok && (center_q < s1_op_q.sample)) begin
      peak = 1'b0;
    end
    if ((s1_op_q.col != '0) && (center_q < left_q)) begin
      peak = 1'b0;
    end
    if (!s1_op_q.last_col && (center_q < right)) begin
      peak = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && peak) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && peak) begin
      row_q <= glmf_pkg::COORD_W'(s1_op_q.row_out);
      col_q <= glmf_pkg::COORD_W'(s1_op_q.col);
    end
  end

  assign out_valid_o = out_valid_q;
  assign peak_row_o  = row_q;
  assign peak_col_o  = col_q;

endmodule

// File: rtl/grid_local_max_finder.sv
// ----------------------------------------------------------------------------
// grid_local_max_finder
// Four-neighbor local maximum detector over a raster-order frame of signed
// samples, reporting the row and column of every peak in raster order.
// ----------------------------------------------------------------------------
// Send the frame one sample per item (kind 0), then frame_width drain ticks
// (kind 1) to decide the last row. A sample is a peak when it is greater than
// or equal to every up, down, left and right neighbor that exists; ties count
// as peaks. Row r-1 is decided while row r arrives, using two line stores
// picked by row parity. Throughput is one item per clock while no result
// stalls: each item costs one read of each line store plus one write, which
// both store ports take in a single cycle. A result passes through the
// request queue, the line store read and the output register. A stalled
// result holds the back end; the four-entry request queue then fills before
// the input stalls. Items that do nothing (a sample while draining, a drain
// tick outside a drain) are accepted and dropped. Write frame_width and
// frame_height only while no request is in flight; a write within a frame
// takes effect from the next item and does not clear the raster position.
module grid_local_max_finder (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration
  input  logic                                    cfg_we_i,
  input  logic [glmf_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [glmf_pkg::CFG_W-1:0]              cfg_wdata_i,
  // input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    kind_i,
  input  logic signed [glmf_pkg::SAMPLE_BITS-1:0] sample_value_i,
  // result channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [glmf_pkg::COORD_W-1:0]            peak_row_o,
  output logic [glmf_pkg::COORD_W-1:0]            peak_col_o
);

  logic          push, full, q_valid, q_pop;
  glmf_pkg::op_t push_op, q_op;

  // classify and sequence the input
  glmf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .sample_value_i (sample_value_i),
    .full_i         (full),
    .push_o         (push),
    .op_o           (push_op)
  );

  // request queue
  glmf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .valid_o   (q_valid),
    .op_o      (q_op),
    .pop_i     (q_pop)
  );

  // line stores, compare and result
  glmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .peak_row_o  (peak_row_o),
    .peak_col_o  (peak_col_o)
  );

endmodule
